// ===== rtl/ssp_pkg.sv =====
// Shared types, constants and the CRC function of the servo status packet receiver.
package ssp_pkg;

  localparam int MAX_PARAMS = 32;
  localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int COUNT_W    = 6;
  localparam int INDEX_W    = 5;
  localparam int ADDR_W     = 3;

  localparam logic [7:0]  HDR_BYTE0  = 8'hFF;
  localparam logic [7:0]  HDR_BYTE1  = 8'hFF;
  localparam logic [7:0]  HDR_BYTE2  = 8'hFD;
  localparam logic [7:0]  RSV_BYTE   = 8'h00;
  localparam logic [7:0]  INSTR_STAT = 8'h55;
  localparam logic [8:0]  ID_ANY     = 9'd256;
  localparam logic [15:0] LEN_MIN    = 16'd4;
  localparam logic [15:0] LEN_MAX    = 16'(MAX_PARAMS + 4);
  localparam logic [15:0] CRC_POLY   = 16'h8005;

  localparam logic REG_ID_FILTER = 1'b0;

  typedef enum logic [1:0] {
    STS_OK  = 2'd0,
    STS_CRC = 2'd1,
    STS_LEN = 2'd2
  } ssp_status_t;

  typedef enum logic [3:0] {
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_RSV,
    ST_ID,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_INSTR,
    ST_ERR,
    ST_PARAM,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic crc_start;
    logic crc_upd;
    logic load_id;
    logic load_len_lo;
    logic load_len_hi;
    logic load_err;
    logic store_param;
    logic load_crc_lo;
    logic cnt_clr;
    logic cnt_inc;
    logic out_len_err;
    logic out_crc_err;
    logic out_empty;
    logic out_param;
  } ssp_cmd_t;

  typedef struct packed {
    logic byte_ff;
    logic byte_fd;
    logic byte_00;
    logic byte_55;
    logic id_ok;
    logic len_bad;
    logic n_zero;
    logic cnt_last;
    logic crc_ok;
    logic out_free;
  } ssp_sts_t;

  typedef struct packed {
    ssp_status_t          status;
    logic [7:0]           servo_id;
    logic [7:0]           error_code;
    logic [COUNT_W-1:0]   param_count;
    logic                 has_param;
    logic [INDEX_W-1:0]   param_index;
    logic [7:0]           param_byte;
    logic                 last;
  } out_item_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/ssp_in_if.sv =====
// Input channel interface carrying one received byte per word.
interface ssp_in_if;
  import ssp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ssp_out_if.sv =====
// Result channel interface carrying one parsed packet result per word.
interface ssp_out_if;
  import ssp_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         servo_id;
  logic [7:0]         error_code;
  logic [COUNT_W-1:0] param_count;
  logic               has_param;
  logic [INDEX_W-1:0] param_index;
  logic [7:0]         param_byte;
  logic               last;

  modport source (output valid, output status, output servo_id, output error_code,
                  output param_count, output has_param, output param_index,
                  output param_byte, output last, input ready);
  modport sink (input valid, input status, input servo_id, input error_code,
                input param_count, input has_param, input param_index,
                input param_byte, input last, output ready);
endinterface

// ===== rtl/ssp_ctrl.sv =====
// Frame parsing state machine that sequences the receiver datapath.
module ssp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::ssp_cmd_t cmd
);
  import ssp_pkg::*;

  ssp_state_t state_r;
  ssp_state_t state_nxt;
  logic       acc;

  assign in_ready = (state_r != ST_EMIT) &&
                    !((state_r inside {ST_LEN_HI, ST_CRC_HI}) && !sts.out_free);
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HDR0: begin
        if (acc && sts.byte_ff) begin
          cmd.crc_start = 1'b1;
          cmd.crc_upd   = 1'b1;
          state_nxt     = ST_HDR1;
        end
      end
      ST_HDR1: begin
        if (acc) begin
          cmd.crc_upd = sts.byte_ff;
          state_nxt   = sts.byte_ff ? ST_HDR2 : ST_HDR0;
        end
      end
      ST_HDR2: begin
        if (acc) begin
          cmd.crc_upd = sts.byte_fd;
          state_nxt   = sts.byte_fd ? ST_RSV : ST_HDR0;
        end
      end
      ST_RSV: begin
        if (acc) begin
          cmd.crc_upd = sts.byte_00;
          state_nxt   = sts.byte_00 ? ST_ID : ST_HDR0;
        end
      end
      ST_ID: begin
        if (acc) begin
          cmd.crc_upd = sts.id_ok;
          cmd.load_id = sts.id_ok;
          state_nxt   = sts.id_ok ? ST_LEN_LO : ST_HDR0;
        end
      end
      ST_LEN_LO: begin
        if (acc) begin
          cmd.crc_upd     = 1'b1;
          cmd.load_len_lo = 1'b1;
          state_nxt       = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (acc) begin
          cmd.crc_upd = 1'b1;
          if (sts.len_bad) begin
            cmd.out_len_err = 1'b1;
            state_nxt       = ST_HDR0;
          end else begin
            cmd.load_len_hi = 1'b1;
            state_nxt       = ST_INSTR;
          end
        end
      end
      ST_INSTR: begin
        if (acc) begin
          cmd.crc_upd = sts.byte_55;
          state_nxt   = sts.byte_55 ? ST_ERR : ST_HDR0;
        end
      end
      ST_ERR: begin
        if (acc) begin
          cmd.crc_upd  = 1'b1;
          cmd.load_err = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_nxt    = sts.n_zero ? ST_CRC_LO : ST_PARAM;
        end
      end
      ST_PARAM: begin
        if (acc) begin
          cmd.crc_upd     = 1'b1;
          cmd.store_param = 1'b1;
          cmd.cnt_inc     = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = ST_CRC_LO;
          end
        end
      end
      ST_CRC_LO: begin
        if (acc) begin
          cmd.load_crc_lo = 1'b1;
          state_nxt       = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (acc) begin
          cmd.cnt_clr = 1'b1;
          if (!sts.crc_ok) begin
            cmd.out_crc_err = 1'b1;
            state_nxt       = ST_HDR0;
          end else if (sts.n_zero) begin
            cmd.out_empty = 1'b1;
            state_nxt     = ST_HDR0;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_param = 1'b1;
          cmd.cnt_inc   = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = ST_HDR0;
          end
        end
      end
      default: begin
        state_nxt = ST_HDR0;
      end
    endcase
  end

  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_ready)
    else $error("Input accepted during the result burst.");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && sts.out_free && sts.cnt_last |=> state_r == ST_HDR0)
    else $error("Result burst did not end after its last word.");

endmodule

// ===== rtl/ssp_datapath.sv =====
// Receiver datapath: packet fields, running CRC, parameter store and result register.
module ssp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic [8:0]        id_filter,
  input  ssp_pkg::ssp_cmd_t cmd,
  output ssp_pkg::ssp_sts_t sts,
  ssp_out_if.source         out_ch
);
  import ssp_pkg::*;

  logic [15:0]        crc_r;
  logic [15:0]        crc_nxt;
  logic [7:0]         crc_lo_r;
  logic [7:0]         id_r;
  logic [7:0]         len_lo_r;
  logic [COUNT_W-1:0] n_r;
  logic [7:0]         err_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [7:0]         param_mem_r [MAX_PARAMS];
  logic               out_valid_r;
  out_item_t          out_r;
  logic [15:0]        len16;
  logic               load_out;

  assign len16   = {in_byte, len_lo_r};
  assign crc_nxt = crc_add(cmd.crc_start ? 16'h0000 : crc_r, in_byte);
  assign load_out = cmd.out_len_err || cmd.out_crc_err || cmd.out_empty || cmd.out_param;

  always_comb begin
    sts          = '0;
    sts.byte_ff  = (in_byte == HDR_BYTE0) && (in_byte == HDR_BYTE1);
    sts.byte_fd  = (in_byte == HDR_BYTE2);
    sts.byte_00  = (in_byte == RSV_BYTE);
    sts.byte_55  = (in_byte == INSTR_STAT);
    sts.id_ok    = (id_filter == ID_ANY) || ({1'b0, in_byte} == id_filter);
    sts.len_bad  = (len16 < LEN_MIN) || (len16 > LEN_MAX);
    sts.n_zero   = (n_r == '0);
    sts.cnt_last = (COUNT_W'(cnt_r) == n_r - COUNT_W'(1));
    sts.crc_ok   = (crc_lo_r == crc_r[7:0]) && (in_byte == crc_r[15:8]);
    sts.out_free = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= '0;
      crc_lo_r <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      n_r      <= '0;
      err_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.crc_upd) begin
        crc_r <= crc_nxt;
      end
      if (cmd.load_crc_lo) begin
        crc_lo_r <= in_byte;
      end
      if (cmd.load_id) begin
        id_r <= in_byte;
      end
      if (cmd.load_len_lo) begin
        len_lo_r <= in_byte;
      end
      if (cmd.load_len_hi) begin
        n_r <= COUNT_W'(len16 - LEN_MIN);
      end
      if (cmd.load_err) begin
        err_r <= in_byte;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_param) begin
      param_mem_r[cnt_r] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.servo_id    <= id_r;
      out_r.has_param   <= cmd.out_param;
      out_r.last        <= cmd.out_param ? sts.cnt_last : 1'b1;
      out_r.param_index <= cmd.out_param ? INDEX_W'(cnt_r) : '0;
      out_r.param_byte  <= cmd.out_param ? param_mem_r[cnt_r] : '0;
      out_r.error_code  <= cmd.out_len_err ? 8'h00 : err_r;
      out_r.param_count <= (cmd.out_len_err || cmd.out_empty) ? '0 : n_r;
      if (cmd.out_len_err) begin
        out_r.status <= STS_LEN;
      end else if (cmd.out_crc_err) begin
        out_r.status <= STS_CRC;
      end else begin
        out_r.status <= STS_OK;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.servo_id    = out_r.servo_id;
  assign out_ch.error_code  = out_r.error_code;
  assign out_ch.param_count = out_r.param_count;
  assign out_ch.has_param   = out_r.has_param;
  assign out_ch.param_index = out_r.param_index;
  assign out_ch.param_byte  = out_r.param_byte;
  assign out_ch.last        = out_r.last;

  a_nopar_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.has_param |-> out_r.last)
    else $error("A result without a parameter is not the last of its packet.");

  a_err_nopar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STS_OK |-> !out_r.has_param)
    else $error("An error result carries a parameter.");

  a_par_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.has_param |-> out_r.param_count != '0)
    else $error("A parameter result reports no parameters.");

endmodule

// ===== rtl/servo_status_packet_receiver.sv =====
// Top level of the servo status packet receiver with its configuration registers.
//
//  Channel   Direction  Handshake               Word
//  in_ch     sink       valid/ready             rx_byte
//  out_ch    source     valid/ready             status, IDs, counts, parameter
//  APB       slave      psel/penable, pready=1  id_filter at byte address 0
//
// One received byte is taken per cycle; a good packet with n parameters then
// sends one result per parameter through the single result register.
// Input stalls during that burst, and on the length and CRC high bytes while
// an earlier result still waits. Reset is synchronous and active low: the
// parser returns to header search and id_filter to 256 (accept any ID).
module servo_status_packet_receiver (
  input  logic                      clk,
  input  logic                      rst_n,
  ssp_in_if.sink                    in_ch,
  ssp_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ssp_pkg::*;

  logic [8:0] id_filter_r;
  ssp_cmd_t   cmd;
  ssp_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ID_FILTER) ? 32'(id_filter_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_filter_r <= ID_ANY;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ID_FILTER) begin
      id_filter_r <= pwdata[8:0];
    end
  end

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.rx_byte),
    .id_filter (id_filter_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule
